### src/sqmm_pkg.sv
// Shared types and constants for the square matrix multiplier.
`timescale 1ns / 1ps
`default_nettype none
package sqmm_pkg;

  localparam int IDX_W  = 3;
  localparam int VAL_W  = 16;
  localparam int PROD_W = 40;

  typedef struct packed {
    logic                    kind;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [VAL_W-1:0] value;
    logic                    start_req;
  } request_t;

  typedef struct packed {
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic signed [PROD_W-1:0] product;
    logic                     last;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;
    logic             issue;
    logic             first;
    logic             final_k;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] k;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pipe_active;
  } status_t;

endpackage
`default_nettype wire

### src/sqmm_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module sqmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### src/sqmm_ctrl.sv
// Controller: request acceptance and the row, column and inner-index sequencer.
`timescale 1ns / 1ps
`default_nettype none
module sqmm_ctrl #(
  parameter int DIM = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               start_req,
  input  wire sqmm_pkg::status_t  status,
  output logic                    busy,
  output sqmm_pkg::cmd_t          cmd
);
  import sqmm_pkg::*;

  localparam int LOG = $clog2(DIM);
  localparam logic [LOG-1:0] MAX_IDX = LOG'(DIM - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]     state, state_next;
  logic [LOG-1:0] r, r_next;
  logic [LOG-1:0] c, c_next;
  logic [LOG-1:0] k, k_next;
  logic           accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_next = state;
    r_next     = r;
    c_next     = c;
    k_next     = k;
    case (state)
      ST_IDLE: begin
        if (accept && start_req) begin
          state_next = ST_RUN;
          r_next     = '0;
          c_next     = '0;
          k_next     = '0;
        end
      end
      ST_RUN: begin
        k_next = k + 1'b1;
        if (k == MAX_IDX) begin
          k_next = '0;
          c_next = c + 1'b1;
          if (c == MAX_IDX) begin
            c_next = '0;
            r_next = r + 1'b1;
            if (r == MAX_IDX) begin
              state_next = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_active) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      r     <= '0;
      c     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      r     <= r_next;
      c     <= c_next;
      k     <= k_next;
    end
  end

  always_comb begin
    cmd.load    = accept;
    cmd.issue   = (state == ST_RUN);
    cmd.first   = (k == '0);
    cmd.final_k = (k == MAX_IDX);
    cmd.row     = IDX_W'(r);
    cmd.col     = IDX_W'(c);
    cmd.k       = IDX_W'(k);
  end

endmodule
`default_nettype wire

### src/sqmm_datapath.sv
// Datapath: matrix stores, multiplier stage, accumulator and result register.
`timescale 1ns / 1ps
`default_nettype none
module sqmm_datapath #(
  parameter int DIM = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sqmm_pkg::request_t request,
  input  wire sqmm_pkg::cmd_t     cmd,
  output sqmm_pkg::status_t       status,
  output logic                    strobe,
  output sqmm_pkg::result_t       result
);
  import sqmm_pkg::*;

  localparam int LOG   = $clog2(DIM);
  localparam int AW    = 2 * LOG;
  localparam int MUL_W = 2 * VAL_W;
  localparam int ACC_W = MUL_W + LOG;
  localparam logic [LOG-1:0] MAX_IDX = LOG'(DIM - 1);

  logic           in_range;
  logic           we_a, we_b;
  logic [AW-1:0]  waddr, raddr_a, raddr_b;
  logic [VAL_W-1:0] rdata_a, rdata_b;

  // Pipeline tags: stage 1 lines up with the read data, stage 2 with the product.
  logic           v1, first1, fin1;
  logic [LOG-1:0] r1, c1;
  logic           v2, first2, fin2;
  logic [LOG-1:0] r2, c2;
  logic signed [MUL_W-1:0] prod2;
  logic signed [ACC_W-1:0] acc, acc_next;

  assign in_range = ({1'b0, request.row_index} < (IDX_W + 1)'(DIM))
                 && ({1'b0, request.col_index} < (IDX_W + 1)'(DIM));
  assign we_a    = cmd.load && in_range && !request.kind;
  assign we_b    = cmd.load && in_range &&  request.kind;
  assign waddr   = {request.row_index[LOG-1:0], request.col_index[LOG-1:0]};
  assign raddr_a = {cmd.row[LOG-1:0], cmd.k[LOG-1:0]};
  assign raddr_b = {cmd.k[LOG-1:0], cmd.col[LOG-1:0]};

  sqmm_ram #(.WIDTH(VAL_W), .DEPTH(DIM * DIM)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (request.value),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  sqmm_ram #(.WIDTH(VAL_W), .DEPTH(DIM * DIM)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (request.value),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      strobe <= 1'b0;
    end else begin
      v1     <= cmd.issue;
      v2     <= v1;
      strobe <= v2 && fin2;
    end
  end

  always_ff @(posedge clk) begin
    first1 <= cmd.first;
    fin1   <= cmd.final_k;
    r1     <= cmd.row[LOG-1:0];
    c1     <= cmd.col[LOG-1:0];
    first2 <= first1;
    fin2   <= fin1;
    r2     <= r1;
    c2     <= c1;
    prod2  <= $signed(rdata_a) * $signed(rdata_b);
  end

  always_comb begin
    if (first2) begin
      acc_next = ACC_W'(prod2);
    end else begin
      acc_next = acc + ACC_W'(prod2);
    end
  end

  always_ff @(posedge clk) begin
    if (v2) begin
      acc <= acc_next;
    end
    if (v2 && fin2) begin
      result.out_row <= IDX_W'(r2);
      result.out_col <= IDX_W'(c2);
      result.product <= PROD_W'(acc_next);
      result.last    <= (r2 == MAX_IDX) && (c2 == MAX_IDX);
    end
  end

  assign status.pipe_active = v1 || v2;

endmodule
`default_nettype wire

### src/square_matrix_multiply.sv
// Top level of the square matrix multiplier: controller, datapath and checks.
//
// Usage: each request written with start high while busy is low is accepted
// and stores one Q8.8 element of A (kind 0) or B (kind 1) at its row and
// column; an element outside the matrix is dropped. A load alone leaves busy
// low, so loads may follow in every cycle.
// A request with start_req set also starts the product once its element is
// stored. busy then rises and stays high while the product runs, at one
// multiply-accumulate per cycle, paced by the single read port of each matrix
// memory, and while the read, multiply and accumulate registers drain.
// The results C[r][c] follow in row-major order on result, each marked by
// strobe for exactly one cycle; last marks C[DIM-1][DIM-1].
// The receiver cannot stall: every strobed result must be taken at once.
// Reset clears the controller and the strobe; the matrix memories keep no
// reset value and every entry must be written before a product reads it.
`timescale 1ns / 1ps
`default_nettype none
module square_matrix_multiply #(
  parameter int DIM = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire sqmm_pkg::request_t request,
  output logic                    busy,
  output logic                    strobe,
  output sqmm_pkg::result_t       result
);
  import sqmm_pkg::*;

  cmd_t    cmd;
  status_t status;

  sqmm_ctrl #(.DIM(DIM)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .start_req (request.start_req),
    .status    (status),
    .busy      (busy),
    .cmd       (cmd)
  );

  sqmm_datapath #(.DIM(DIM)) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .status  (status),
    .strobe  (strobe),
    .result  (result)
  );

  // A result is only ever delivered while a product is in progress.
  assert property (@(posedge clk) disable iff (rst) strobe |-> busy)
    else $error("result strobed while idle");

  // The final element ends the product run.
  assert property (@(posedge clk) disable iff (rst) (strobe && result.last) |=> !busy)
    else $error("still busy after the final element");

  // A plain load never makes the block busy.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !request.start_req) |=> !busy)
    else $error("busy after a load without a start request");

  // The multiply-accumulate pipeline runs only while busy.
  assert property (@(posedge clk) disable iff (rst) status.pipe_active |-> busy)
    else $error("pipeline active while idle");

endmodule
`default_nettype wire
